FILE: hw/rtl/bedf_pkg.sv
package bedf_pkg;

  // Sizes
  localparam int MAX_TARGET_DEF = 32;
  localparam int DIST_W         = 8;
  localparam int DIST_MAX       = 255;
  localparam int LETTER_W       = 5;
  localparam int POS_W          = 5;
  localparam int TLEN_W         = 6;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_WORD = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_DISTANCE  = 1'b0;
  localparam logic REG_TARGET_LENGTH = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [POS_W-1:0]    position;
    logic [LETTER_W-1:0] letter;
    logic                last_of_word;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              within_limit;
  } out_item_t;

  // Target letter write, broadcast to every cell
  typedef struct packed {
    logic                en;
    logic [POS_W-1:0]    position;
    logic [LETTER_W-1:0] letter;
  } load_t;

  // Wavefront token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] letter;
    logic [DIST_W-1:0]   diag;
    logic [DIST_W-1:0]   left;
    logic                rebuild;
  } wave_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] x);
    return (x == DIST_W'(DIST_MAX)) ? x : x + DIST_W'(1);
  endfunction

  function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

FILE: hw/rtl/bedf_cell.sv
module bedf_cell #(
  parameter int IDX = 1,
  parameter int NW  = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [NW-1:0]   n,
  input  bedf_pkg::load_t load,
  input  bedf_pkg::wave_t wave_in,
  output bedf_pkg::wave_t wave_out
);
  import bedf_pkg::*;

  localparam logic [DIST_W-1:0] INIT_DIST =
    (IDX < DIST_MAX) ? DIST_W'(IDX) : DIST_W'(DIST_MAX);

  logic [LETTER_W-1:0] target_letter;
  logic [DIST_W-1:0]   row;
  logic [DIST_W-1:0]   up;
  logic [DIST_W-1:0]   cost;
  logic [DIST_W-1:0]   row_next;
  logic                active;

  // Only cells up to the current target length take part
  assign active = wave_in.valid && (32'(n) >= 32'(IDX));

  // One Levenshtein step for this target position
  assign up       = wave_in.rebuild ? INIT_DIST : row;
  assign cost     = (target_letter == wave_in.letter) ? wave_in.diag : sat_inc(wave_in.diag);
  assign row_next = min3(cost, sat_inc(wave_in.left), sat_inc(up));

  // Stored target letter
  always_ff @(posedge clk) begin
    if (load.en && (32'(load.position) == 32'(IDX - 1))) begin
      target_letter <= load.letter;
    end
  end

  // Row entry
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= INIT_DIST;
    end else if (active) begin
      row <= row_next;
    end
  end

  // Token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    wave_out.letter  <= wave_in.letter;
    wave_out.diag    <= up;
    wave_out.left    <= row_next;
    wave_out.rebuild <= wave_in.rebuild;
  end

endmodule

FILE: hw/rtl/bounded_edit_distance_filter_top.sv
// Bounded edit distance filter.
// Input channel (in_valid/in_ready/in_data) carries load items and word letters.
// A load item writes one target letter; it gives no result. A word letter
// advances the distance row through a chain of cells, one cell per target
// position, the token moving one cell each cycle. With n the active target
// length, no item is taken while a token is on its way to cell n (for n = 0
// no token is launched). The final letter of a word shows its result on
// out_valid/out_data once its token leaves cell n. The chain length (MAX_TARGET
// cells) bounds n; the token walk sets the rate. The result sits in an output
// register; while it waits, loads and non-final letters are still taken, but a
// final letter waits until the register is free. Registers max_distance and
// target_length are to be written over the APB port only while the block is
// idle; the block itself does not enforce this. Reset clears both registers,
// sets the row to 0,1,2,.. and marks the next word letter as the start of a
// word. Target letters are not cleared and must be loaded before use.
module bounded_edit_distance_filter_top #(
  parameter int MAX_TARGET = bedf_pkg::MAX_TARGET_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bedf_pkg::ADDR_W-1:0] paddr,
  input  logic [bedf_pkg::DATA_W-1:0] pwdata,
  output logic [bedf_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bedf_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bedf_pkg::out_item_t         out_data
);
  import bedf_pkg::*;

  localparam int NW = $clog2(MAX_TARGET + 1);

  logic [DIST_W-1:0] max_distance;
  logic [TLEN_W-1:0] target_length;
  logic [DIST_W-1:0] row0;
  logic              word_start;
  logic              busy;
  logic [NW-1:0]     n_cur;
  logic [NW-1:0]     n_act;
  wave_t             wave [0:MAX_TARGET];
  load_t             load;
  logic              accept;
  logic              word_acc;
  logic              cfg_wr;
  logic [DIST_W-1:0] old0;
  logic [DIST_W-1:0] new0;
  logic              fin;
  logic [DIST_W-1:0] fin_dist;
  logic              res_valid;
  logic [DIST_W-1:0] res_dist;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance  <= '0;
      target_length <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAX_DISTANCE:  max_distance  <= pwdata[DIST_W-1:0];
        REG_TARGET_LENGTH: target_length <= pwdata[TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_DISTANCE:  prdata = DATA_W'(max_distance);
      REG_TARGET_LENGTH: prdata = DATA_W'(target_length);
      default:           prdata = '0;
    endcase
  end

  // Active length, clamped to the chain
  always_comb begin
    if (32'(target_length) > 32'(MAX_TARGET)) begin
      n_act = NW'(MAX_TARGET);
    end else begin
      n_act = NW'(target_length);
    end
  end

  // Input handshake: a final letter needs a free result register
  assign in_ready = !busy && ((in_data.operation == OP_LOAD) || !in_data.last_of_word ||
                              !out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign word_acc = accept && (in_data.operation == OP_WORD);

  // Target letter writes
  assign load.en       = accept && (in_data.operation == OP_LOAD);
  assign load.position = in_data.position;
  assign load.letter   = in_data.letter;

  // Column zero of the row
  assign old0 = word_start ? '0 : row0;
  assign new0 = sat_inc(old0);

  always_ff @(posedge clk) begin
    if (rst) begin
      row0       <= '0;
      word_start <= 1'b1;
    end else if (word_acc) begin
      row0       <= new0;
      word_start <= in_data.last_of_word;
    end
  end

  // Launch a token into the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      wave[0].valid <= 1'b0;
    end else begin
      wave[0].valid <= word_acc && (n_act != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (word_acc) begin
      wave[0].letter  <= in_data.letter;
      wave[0].diag    <= old0;
      wave[0].left    <= new0;
      wave[0].rebuild <= word_start;
      n_cur           <= n_act;
    end
  end

  // Chain of cells, one per target position
  for (genvar j = 1; j <= MAX_TARGET; j++) begin : g_cell
    bedf_cell #(
      .IDX (j),
      .NW  (NW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .n        (n_cur),
      .load     (load),
      .wave_in  (wave[j-1]),
      .wave_out (wave[j])
    );
  end

  // Pick the token leaving cell n
  always_comb begin
    fin      = 1'b0;
    fin_dist = '0;
    for (int j = 1; j <= MAX_TARGET; j++) begin
      if (wave[j].valid && (32'(n_cur) == 32'(j))) begin
        fin      = 1'b1;
        fin_dist = fin_dist | wave[j].left;
      end
    end
  end

  // Chain busy while a token is on its way to cell n
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (fin) begin
      busy <= 1'b0;
    end else if (word_acc && (n_act != '0)) begin
      busy <= 1'b1;
    end
  end

  // Result source: chain end, or column zero for an empty target
  always_comb begin
    res_valid = 1'b0;
    res_dist  = fin_dist;
    if (fin) begin
      // word_start holds last_of_word of the letter still in the chain
      res_valid = word_start;
    end else if (word_acc && in_data.last_of_word && (n_act == '0)) begin
      res_valid = 1'b1;
      res_dist  = new0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data.distance     <= res_dist;
      out_data.within_limit <= (res_dist <= max_distance);
    end
  end

endmodule

FILE: hw/rtl/bedf_checker.sv
module bedf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [bedf_pkg::ADDR_W-1:0] paddr,
  input logic [bedf_pkg::DATA_W-1:0] pwdata,
  input logic                        pready,
  input logic                        in_valid,
  input logic                        in_ready,
  input bedf_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input bedf_pkg::out_item_t         out_data
);
  import bedf_pkg::*;

  logic [DIST_W-1:0] max_dist_seen;

  // Track the match limit from the register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist_seen <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_DISTANCE)) begin
      max_dist_seen <= pwdata[DIST_W-1:0];
    end
  end

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // Match flag agrees with the limit
  a_within: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.within_limit == (out_data.distance <= max_dist_seen)))
    else $error("within_limit disagrees with distance");

  // A final letter is only taken when the result register can take its result
  a_final_room: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.operation == OP_WORD) && in_data.last_of_word
    |-> !out_valid || out_ready)
    else $error("final letter taken over a pending result");

  // Loads never raise a result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.operation == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("result after a load item");

endmodule

bind bounded_edit_distance_filter_top bedf_checker u_bedf_checker (.*);

FILE: sim/bounded_edit_distance_filter_top_tb.sv
module bounded_edit_distance_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bedf_pkg::*;

  typedef logic [LETTER_W-1:0] letter_t;

  localparam int SETTLE       = 40;   // covers the longest token walk through the chain
  localparam int IDLE_PCT     = 25;
  localparam int RANDOM_ITEMS = 550;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;

  bit                  no_gaps = 1'b0;
  int                  queued  = 0;
  int unsigned         mismatches = 0;

  in_item_t            stream_q[$];     // items waiting to be driven
  out_item_t           distance_q[$];   // predicted results, oldest first
  letter_t             word_q[$];       // word under construction

  // Target as the generator sees it, updated when a load is queued
  letter_t             plan_letters [MAX_TARGET_DEF];

  // Predictor state, updated on each input transfer
  letter_t             held_letters [MAX_TARGET_DEF];
  logic [DIST_W-1:0]   row_cost [MAX_TARGET_DEF+1];
  bit                  new_word = 1'b1;
  logic [DIST_W-1:0]   lim_dist = '0;
  logic [TLEN_W-1:0]   tgt_len  = '0;

  bounded_edit_distance_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [DIST_W-1:0] bump(input logic [DIST_W-1:0] v);
    bump = (v == '1) ? v : v + 1'b1;
  endfunction

  // One Levenshtein row step per word letter; loads only touch the target
  task automatic advance_row(input in_item_t it);
    int                n;
    logic [DIST_W-1:0] diag, up, run, cost;
    out_item_t         res;
    if (it.operation == OP_LOAD) begin
      held_letters[it.position] = it.letter;
    end else begin
      n = (int'(tgt_len) > MAX_TARGET_DEF) ? MAX_TARGET_DEF : int'(tgt_len);
      if (new_word) begin
        for (int j = 0; j <= n; j++) row_cost[j] = DIST_W'(j);
      end
      diag = row_cost[0];
      run = bump(diag);
      row_cost[0] = run;
      for (int j = 1; j <= n; j++) begin
        up = row_cost[j];
        cost = (held_letters[j-1] == it.letter) ? diag : bump(diag);
        if (bump(run) < cost) cost = bump(run);
        if (bump(up) < cost) cost = bump(up);
        run = cost;
        row_cost[j] = run;
        diag = up;
      end
      if (it.last_of_word) begin
        res.distance     = row_cost[n];
        res.within_limit = (row_cost[n] <= lim_dist);
        distance_q = {distance_q, res};
        new_word = 1'b1;
      end else begin
        new_word = 1'b0;
      end
    end
  endtask

  // Input driver: holds payload until the transfer, then maybe idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) advance_row(in_data);
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          in_data  <= stream_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (distance_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: distance %0d within %0b",
                     $realtime, out_data.distance, out_data.within_limit);
        end else begin
          want = distance_q.pop_front();
          if (out_data.distance != want.distance ||
              out_data.within_limit != want.within_limit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: distance %0d/%0d within %0b/%0b (exp/got)",
                       $realtime, want.distance, out_data.distance,
                       want.within_limit, out_data.within_limit);
          end
        end
      end
      out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic queue_item(input logic op, input int pos, input int code, input logic last);
    in_item_t it;
    it.operation    = op;
    it.position     = POS_W'(pos);
    it.letter       = LETTER_W'(code);
    it.last_of_word = last;
    if (op == OP_LOAD) plan_letters[pos] = LETTER_W'(code);
    stream_q = {stream_q, it};
    queued++;
  endtask

  // Queue word_q as word letters; loads may slip in between letters
  task automatic queue_word(input bit finish);
    int sz;
    sz = word_q.size();
    for (int i = 0; i < sz; i++) begin
      queue_item(OP_WORD, $urandom_range(0, 31), int'(word_q[i]), finish && (i == sz - 1));
      if (i != sz - 1 && $urandom_range(0, 11) == 0)
        queue_item(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                   1'($urandom_range(0, 1)));
    end
  endtask

  // Mostly a lightly edited copy of the target, sometimes pure noise
  task automatic make_word(input int n);
    int k;
    word_q.delete();
    if (n == 0 || $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, n + 4)) word_q = {word_q, letter_t'($urandom_range(0, 31))};
    end else begin
      for (int j = 0; j < n; j++) word_q = {word_q, plan_letters[j]};
      repeat ($urandom_range(0, 3)) begin
        k = $urandom_range(0, word_q.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            word_q[k] = letter_t'($urandom_range(0, 31));
          end
          1: begin
            if (word_q.size() > 1) word_q.delete(k);
          end
          default: begin
            word_q.insert(k, letter_t'($urandom_range(0, 31)));
          end
        endcase
      end
    end
  endtask

  task automatic apb_write(input logic idx, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAX_DISTANCE) lim_dist = DIST_W'(value);
    else tgt_len = TLEN_W'(value);
  endtask

  // Wait for every transfer and result, then let the chain empty
  task automatic drain();
    do @(negedge clk); while (stream_q.size() != 0 || in_valid || distance_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int start, p, n, md, words;
    for (int j = 0; j <= MAX_TARGET_DEF; j++) row_cost[j] = DIST_W'(j);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty target at reset settings: distance is the word length
    word_q = '{0};
    queue_word(1);
    word_q = '{31, 26, 0};
    queue_word(1);
    // Fill the whole store, letter equal to position, so nothing is read unwritten
    for (int j = 0; j < MAX_TARGET_DEF; j++)
      queue_item(OP_LOAD, j, j, 1'($urandom_range(0, 1)));
    drain();

    apb_write(REG_MAX_DISTANCE, 2);
    apb_write(REG_TARGET_LENGTH, 5);
    word_q = '{0, 1, 2, 3, 4};
    queue_word(1);
    word_q = '{0, 1, 9, 3, 4};
    queue_word(1);
    word_q = '{1, 2, 3};
    queue_word(1);
    word_q = '{31, 30, 29};
    queue_word(1);
    // Word left open across a length change
    word_q = '{0, 1};
    queue_word(0);
    drain();
    apb_write(REG_TARGET_LENGTH, 8);
    word_q = '{2, 3};
    queue_word(1);
    drain();

    // Length above the chain size clamps to the full chain
    apb_write(REG_TARGET_LENGTH, 63);
    apb_write(REG_MAX_DISTANCE, 255);
    word_q = '{0, 1, 2};
    queue_word(1);
    drain();

    // Saturation at the top of the distance range, with and without a match
    apb_write(REG_TARGET_LENGTH, 0);
    word_q.delete();
    repeat (300) word_q = {word_q, letter_t'($urandom_range(0, 31))};
    queue_word(1);
    drain();
    apb_write(REG_MAX_DISTANCE, 254);
    word_q.delete();
    repeat (257) word_q = {word_q, letter_t'($urandom_range(0, 31))};
    queue_word(1);
    drain();

    // Random phases, each with its own settings and target
    start = queued;
    p = 0;
    while (queued - start < RANDOM_ITEMS) begin
      if (p == 0) begin
        n = MAX_TARGET_DEF;
      end else if (p == 1) begin
        n = 1;
      end else begin
        case ($urandom_range(0, 7))
          0:       n = 0;
          1:       n = $urandom_range(33, 63);
          2, 3:    n = $urandom_range(9, MAX_TARGET_DEF);
          default: n = $urandom_range(1, 8);
        endcase
      end
      if (p == 0) begin
        md = 0;
      end else begin
        case ($urandom_range(0, 4))
          0:       md = 255;
          1:       md = 0;
          default: md = $urandom_range(0, 8);
        endcase
      end
      // First phase runs with no idling on either side
      no_gaps = (p == 0);
      apb_write(REG_MAX_DISTANCE, md);
      apb_write(REG_TARGET_LENGTH, n);
      if (n > MAX_TARGET_DEF) n = MAX_TARGET_DEF;
      md = $urandom_range(0, 1);   // narrow alphabet makes near matches likely
      for (int j = 0; j < n; j++)
        queue_item(OP_LOAD, j, md ? $urandom_range(0, 3) : $urandom_range(0, 31),
                   1'($urandom_range(0, 1)));
      words = (p == 0) ? 12 : $urandom_range(4, 12);
      for (int w = 0; w < words; w++) begin
        make_word(n);
        queue_word(!(w == words - 1 && $urandom_range(0, 3) == 0));
      end
      drain();
      p++;
    end
    no_gaps = 1'b0;

    if (mismatches == 0 && distance_q.size() == 0) begin
      $display("bounded_edit_distance_filter_top_tb: done, clean");
    end else begin
      $display("bounded_edit_distance_filter_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("bounded_edit_distance_filter_top_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bedf_pkg.sv
hw/rtl/bedf_cell.sv
hw/rtl/bounded_edit_distance_filter_top.sv
hw/rtl/bedf_checker.sv
sim/bounded_edit_distance_filter_top_tb.sv
